// ===== sv/plt_pkg.sv =====
`timescale 1ns / 1ps

package plt_pkg;

	localparam int unsigned CH_W      = 8;
	localparam int unsigned RGB_W     = 3 * CH_W;
	localparam int unsigned IDX_W     = 16;
	localparam int unsigned PIX_W     = 32;
	// |2*delta| is at most 510: nine dividend bits, one quotient bit per cycle
	localparam int unsigned DIV_STEPS = CH_W + 1;
	localparam int unsigned DIV_CNT_W = 4;
	localparam int unsigned QD_W      = CH_W + 2;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_POINT  = 2'd1,
		OP_LOOKUP = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_BEYOND = 2'd1,
		STAT_BELOW  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PREP,
		S_DIV,
		S_FIX,
		S_STEP
	} state_t;

	typedef struct packed {
		logic load;
		logic div;
		logic fix;
		logic step;
	} lane_ctrl_t;

endpackage

// ===== sv/palette_lut_interp_lookup.sv =====
`timescale 1ns / 1ps

// Piecewise-linear RGB palette. Items come in on in_valid/in_ready with an
// opcode: clear, load control point, or look up pixel. Every item gives
// exactly one result on out_valid/out_ready, in order.
// Lookups stream at one item per cycle while no fill runs and the receiver
// keeps up; a result passes through the synchronous table read and then the
// output register. Clears and points that need no fill flow through the same way.
// A point more than one entry past the previous point fills the entries
// between by exact rounded interpolation: after it is accepted the input is
// held off while the left endpoint is fetched, the color deltas are divided
// bit-serially by 2*span, a setup step runs, and then one table write per
// filled entry is made on the single write port.
// A clear resets the high-water index: entries never written since the last
// clear read as zero through that index, so no clearing pass is needed, at
// reset or later. Reset empties the pipeline and the table.
// When the receiver stalls, one result waits in the output register and one
// more in the read stage; outside a fill, input waits only when both are full.
module palette_lut_interp_lookup import plt_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = 4096
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [1:0]              opcode,
	input  logic [IDX_W-1:0]        point_index,
	input  logic [CH_W-1:0]         point_red,
	input  logic [CH_W-1:0]         point_green,
	input  logic [CH_W-1:0]         point_blue,
	input  logic signed [PIX_W-1:0] pixel_value,
	input  logic                    last_pixel,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [CH_W-1:0]         red_out,
	output logic [CH_W-1:0]         green_out,
	output logic [CH_W-1:0]         blue_out,
	output logic [1:0]              status,
	output logic [IDX_W-1:0]        highest_index,
	output logic                    last_out
);

	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned DW = AW + 1;
	localparam logic [IDX_W:0]   DEPTH_X  = (IDX_W + 1)'(TABLE_DEPTH);
	localparam logic [PIX_W-1:0] PIX_MAX  = PIX_W'(TABLE_DEPTH - 1);
	localparam logic [AW-1:0]    ADDR_MAX = AW'(TABLE_DEPTH - 1);

	state_t state_q, state_nxt;

	// prev_q is both the last accepted point and the highest one since clear
	logic [AW-1:0]        prev_q;
	logic                 zero_q;
	logic [AW-1:0]        pos_q;
	logic [AW-1:0]        end_q;
	logic [AW-1:0]        span_q;
	logic                 a_ok_q;
	logic [RGB_W-1:0]     b_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;

	logic                 v_s1;
	logic                 lk_s1;
	logic                 ok_s1;
	status_t              status_s1;
	logic [IDX_W-1:0]     high_s1;
	logic                 last_s1;

	logic                 out_valid_q;
	logic [CH_W-1:0]      red_q;
	logic [CH_W-1:0]      green_q;
	logic [CH_W-1:0]      blue_q;
	status_t              status_q;
	logic [IDX_W-1:0]     high_q;
	logic                 last_q;

	logic                 adv;
	logic                 in_acc;
	opcode_t              op;
	logic [AW-1:0]        idx_a;
	logic                 pt_ok;
	status_t              stat_nxt;
	logic [AW-1:0]        span;
	logic                 fill_start;
	logic [AW-1:0]        pix_addr;
	logic                 lk_ok;
	logic [IDX_W-1:0]     high_nxt;

	lane_ctrl_t           lane_ctrl;
	logic [DW-1:0]        divisor;
	logic [RGB_W-1:0]     a_rgb;
	logic [RGB_W-1:0]     fill_rgb;

	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [RGB_W-1:0]     mem_wdata;
	logic [AW-1:0]        mem_raddr;
	logic [RGB_W-1:0]     rdata;

	assign adv    = !out_valid_q || out_ready;
	assign in_acc = in_valid && in_ready;

	// item decode
	always_comb begin
		op         = opcode_t'(opcode);
		idx_a      = point_index[AW-1:0];
		pt_ok      = 1'b0;
		stat_nxt   = STAT_OK;
		span       = idx_a - prev_q;
		high_nxt   = IDX_W'(prev_q);
		case (op)
			OP_CLEAR: begin
				high_nxt = '0;
			end
			OP_POINT: begin
				if ({1'b0, point_index} >= DEPTH_X) begin
					stat_nxt = STAT_BEYOND;
				end else if (idx_a < prev_q) begin
					stat_nxt = STAT_BELOW;
				end else begin
					pt_ok    = 1'b1;
					high_nxt = IDX_W'(idx_a);
				end
			end
			default: begin
			end
		endcase
		fill_start = pt_ok && (span > AW'(1));

		if (pixel_value[PIX_W-1]) begin
			pix_addr = '0;
		end else if ($unsigned(pixel_value) > PIX_MAX) begin
			pix_addr = ADDR_MAX;
		end else begin
			pix_addr = pixel_value[AW-1:0];
		end
		// written entries since clear: 1..prev_q, and 0 once a point lands there
		lk_ok = (pix_addr == '0) ? zero_q : (pix_addr <= prev_q);
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_acc && fill_start) begin
					state_nxt = S_PREP;
				end
			end
			S_PREP: begin
				state_nxt = S_DIV;
			end
			S_DIV: begin
				if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					state_nxt = S_FIX;
				end
			end
			S_FIX: begin
				state_nxt = S_STEP;
			end
			S_STEP: begin
				if (pos_q == end_q) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		lane_ctrl = '0;
		mem_we    = 1'b0;
		mem_waddr = idx_a;
		mem_wdata = {point_red, point_green, point_blue};
		case (state_q)
			S_IDLE: begin
				in_ready = !v_s1 || adv;
				mem_we   = in_acc && pt_ok;
			end
			S_PREP: begin
				lane_ctrl.load = 1'b1;
			end
			S_DIV: begin
				lane_ctrl.div = 1'b1;
			end
			S_FIX: begin
				lane_ctrl.fix = 1'b1;
			end
			S_STEP: begin
				lane_ctrl.step = 1'b1;
				mem_we         = 1'b1;
				mem_waddr      = pos_q;
				mem_wdata      = fill_rgb;
			end
			default: begin
			end
		endcase
	end

	assign mem_raddr = (op == OP_LOOKUP) ? pix_addr : prev_q;

	plt_mem #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (in_acc),
		.raddr (mem_raddr),
		.rdata (rdata)
	);

	assign divisor = {span_q, 1'b0};
	assign a_rgb   = a_ok_q ? rdata : '0;

	for (genvar c = 0; c < 3; c++) begin : g_lane
		plt_lane #(
			.DW (DW)
		) u_lane (
			.clk     (clk),
			.ctrl    (lane_ctrl),
			.a       (a_rgb[c*CH_W +: CH_W]),
			.b       (b_q[c*CH_W +: CH_W]),
			.divisor (divisor),
			.value   (fill_rgb[c*CH_W +: CH_W])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			prev_q    <= '0;
			zero_q    <= 1'b0;
			div_cnt_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (in_acc && op == OP_CLEAR) begin
				prev_q <= '0;
				zero_q <= 1'b0;
			end else if (in_acc && pt_ok) begin
				prev_q <= idx_a;
				if (idx_a == '0) begin
					zero_q <= 1'b1;
				end
			end
			if (state_q == S_DIV) begin
				div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
			end else begin
				div_cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && fill_start) begin
			pos_q  <= prev_q + AW'(1);
			end_q  <= idx_a - AW'(1);
			span_q <= span;
			a_ok_q <= (prev_q != '0) || zero_q;
			b_q    <= {point_red, point_green, point_blue};
		end else if (state_q == S_STEP) begin
			pos_q <= pos_q + AW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			lk_s1     <= op == OP_LOOKUP;
			ok_s1     <= lk_ok;
			status_s1 <= stat_nxt;
			high_s1   <= high_nxt;
			last_s1   <= (op == OP_LOOKUP) && last_pixel;
		end
		if (adv && v_s1) begin
			red_q    <= (lk_s1 && ok_s1) ? rdata[2*CH_W +: CH_W] : '0;
			green_q  <= (lk_s1 && ok_s1) ? rdata[CH_W +: CH_W] : '0;
			blue_q   <= (lk_s1 && ok_s1) ? rdata[0 +: CH_W] : '0;
			status_q <= status_s1;
			high_q   <= high_s1;
			last_q   <= last_s1;
		end
	end

	assign out_valid     = out_valid_q;
	assign red_out       = red_q;
	assign green_out     = green_q;
	assign blue_out      = blue_q;
	assign status        = status_q;
	assign highest_index = high_q;
	assign last_out      = last_q;

`ifndef NO_ASSERTIONS
	a_prev_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_acc && op == OP_CLEAR) |=> prev_q >= $past(prev_q))
		else $error("control point index went backwards without a clear");

	a_div_length: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PREP |-> ##(DIV_STEPS + 1) state_q == S_FIX)
		else $error("divider did not finish in the expected number of cycles");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_STEP |-> pos_q <= end_q)
		else $error("fill write ran past the new control point");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv |=> v_s1 && $stable(status_s1) && $stable(high_s1))
		else $error("read-stage item lost while output stalled");
`endif

endmodule

// ===== sv/plt_mem.sv =====
`timescale 1ns / 1ps

module plt_mem import plt_pkg::*; #(
	parameter int unsigned DEPTH = 4096,
	parameter int unsigned AW    = 12
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [RGB_W-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [RGB_W-1:0] rdata
);

	logic [RGB_W-1:0] mem [DEPTH];
	logic [RGB_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/plt_lane.sv =====
`timescale 1ns / 1ps

// One color channel of the span fill. A bit-serial divider splits 2*delta
// into quotient and remainder over the divisor 2*span once per span; after
// that each step adds them to a running value/remainder pair, which tracks
// floor((2*(a*(span-k) + b*k) + span) / (2*span)) exactly.
module plt_lane import plt_pkg::*; #(
	parameter int unsigned DW = 13
) (
	input  logic            clk,
	input  lane_ctrl_t      ctrl,
	input  logic [CH_W-1:0] a,
	input  logic [CH_W-1:0] b,
	input  logic [DW-1:0]   divisor,
	output logic [CH_W-1:0] value
);

	logic [CH_W-1:0]             v_q;
	logic [DW-1:0]               r_q;
	logic [DIV_STEPS-1:0]        u_q;
	logic [DIV_STEPS-1:0]        quo_q;
	logic [DW-1:0]               rem_q;
	logic                        neg_q;
	logic signed [QD_W-1:0]      qd_q;
	logic [DW-1:0]               rd_q;

	logic signed [QD_W-1:0]      diff;
	logic [QD_W-1:0]             mag;
	logic [DIV_STEPS-1:0]        u_init;
	logic [DW:0]                 rem_ext;
	logic                        rem_ge;
	logic [DW-1:0]               rem_nxt;
	logic [QD_W-1:0]             q_ext;
	logic signed [QD_W-1:0]      qd_nxt;
	logic [DW-1:0]               rd_nxt;
	logic [DW:0]                 r_sum;
	logic signed [QD_W-1:0]      v_sum;
	logic                        wrap;
	logic [DW-1:0]               r_step;
	logic signed [QD_W-1:0]      v_step;

	always_comb begin
		diff   = signed'({2'b00, b}) - signed'({2'b00, a});
		mag    = diff[QD_W-1] ? QD_W'(-diff) : QD_W'(diff);
		u_init = {mag[CH_W-1:0], 1'b0};
	end

	// restoring divider, one quotient bit per cycle
	always_comb begin
		rem_ext = {rem_q, u_q[DIV_STEPS-1]};
		rem_ge  = rem_ext >= {1'b0, divisor};
		rem_nxt = rem_ge ? DW'(rem_ext - {1'b0, divisor}) : rem_ext[DW-1:0];
	end

	// floor division for a negative delta
	always_comb begin
		q_ext = {1'b0, quo_q};
		if (!neg_q) begin
			qd_nxt = signed'(q_ext);
			rd_nxt = rem_q;
		end else if (rem_q != '0) begin
			qd_nxt = signed'(~q_ext);
			rd_nxt = divisor - rem_q;
		end else begin
			qd_nxt = signed'(QD_W'(-q_ext));
			rd_nxt = '0;
		end
	end

	always_comb begin
		r_sum  = {1'b0, r_q} + {1'b0, rd_q};
		v_sum  = signed'({2'b00, v_q}) + qd_q;
		wrap   = r_sum >= {1'b0, divisor};
		r_step = wrap ? DW'(r_sum - {1'b0, divisor}) : r_sum[DW-1:0];
		v_step = wrap ? v_sum + signed'(QD_W'(1)) : v_sum;
		value  = v_step[CH_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			v_q   <= a;
			r_q   <= DW'(divisor >> 1);
			u_q   <= u_init;
			neg_q <= diff[QD_W-1];
			rem_q <= '0;
			quo_q <= '0;
		end else if (ctrl.div) begin
			u_q   <= {u_q[DIV_STEPS-2:0], 1'b0};
			rem_q <= rem_nxt;
			quo_q <= {quo_q[DIV_STEPS-2:0], rem_ge};
		end else if (ctrl.fix) begin
			qd_q <= qd_nxt;
			rd_q <= rd_nxt;
		end else if (ctrl.step) begin
			v_q <= value;
			r_q <= r_step;
		end
	end

endmodule
